// File: hdl/lfdc_pkg.sv
// Shared types, constants and helper functions for the line-follow drive controller.
package lfdc_pkg;

    localparam int CFG_BITS   = 24;
    localparam int DUTY_BITS  = 7;
    localparam int DIR_BITS   = 3;
    localparam int IDX_BITS   = 2;
    localparam int TIMER_BITS_DEFAULT = 24;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX    = 7'd100;
    localparam logic [DUTY_BITS-1:0] DUTY_MIN_ON = 7'd1;
    localparam logic [DUTY_BITS-1:0] DUTY_OFF    = 7'd0;

    localparam logic [CFG_BITS-1:0] BLINK_PERIOD_RESET = 24'd300;
    localparam logic [CFG_BITS-1:0] TURN_SETTLE_RESET  = 24'd1000;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_FWD   = 3'd0,
        DIR_BACK  = 3'd1,
        DIR_STOP  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_BLINK_PERIOD = 2'd0,
        CFG_TURN_SETTLE  = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PAT_UNKNOWN     = 2'd0,
        PAT_CENTRE      = 2'd1,
        PAT_STEER_RIGHT = 2'd2,
        PAT_STEER_LEFT  = 2'd3
    } pattern_t;

    // Bridge pins and duties for one tick.
    typedef struct packed {
        logic                 left_fwd;
        logic                 left_rev;
        logic                 right_fwd;
        logic                 right_rev;
        logic [DUTY_BITS-1:0] left_duty;
        logic [DUTY_BITS-1:0] right_duty;
    } drive_t;

    // Lamp levels and turn completion after one tick.
    typedef struct packed {
        logic left_lamp;
        logic right_lamp;
        logic turn_done;
    } turn_status_t;

    // Codes above the right turn behave as stop.
    function automatic dir_t sanitize_dir(input logic [DIR_BITS-1:0] raw);
        dir_t d;
        case (raw)
            DIR_FWD:   d = DIR_FWD;
            DIR_BACK:  d = DIR_BACK;
            DIR_LEFT:  d = DIR_LEFT;
            DIR_RIGHT: d = DIR_RIGHT;
            default:   d = DIR_STOP;
        endcase
        return d;
    endfunction

    function automatic pattern_t classify(input logic l, input logic m, input logic r);
        pattern_t p;
        if (!l && !r && m) begin
            p = PAT_CENTRE;
        end else if (l && !r) begin
            p = PAT_STEER_RIGHT;
        end else if (!l && r) begin
            p = PAT_STEER_LEFT;
        end else begin
            p = PAT_UNKNOWN;
        end
        return p;
    endfunction

endpackage

// File: hdl/lfdc_drive.sv
// Combinational bridge direction and duty selection for one tick.
module lfdc_drive (
    input  logic [lfdc_pkg::DIR_BITS-1:0]  direction_cmd,
    input  logic [lfdc_pkg::DUTY_BITS-1:0] speed,
    input  logic                           sensor_left,
    input  logic                           sensor_middle,
    input  logic                           sensor_right,
    output lfdc_pkg::drive_t               drive
);
    import lfdc_pkg::*;

    dir_t                 dir;
    pattern_t             pat;
    logic [DUTY_BITS-1:0] spd;

    assign dir = sanitize_dir(direction_cmd);
    assign pat = classify(sensor_left, sensor_middle, sensor_right);
    assign spd = (speed > DUTY_MAX) ? DUTY_MAX : speed;

    always_comb begin
        drive = '0;
        drive.left_duty  = spd;
        drive.right_duty = spd;
        unique case (dir)
            DIR_FWD: begin
                drive.left_fwd  = 1'b1;
                drive.right_fwd = 1'b1;
                if (pat == PAT_STEER_LEFT) begin
                    drive.left_duty  = DUTY_MAX;
                    drive.right_duty = DUTY_MIN_ON;
                end else if (pat == PAT_STEER_RIGHT) begin
                    drive.left_duty  = DUTY_MIN_ON;
                    drive.right_duty = DUTY_MAX;
                end
            end
            DIR_BACK: begin
                drive.left_rev  = 1'b1;
                drive.right_rev = 1'b1;
            end
            DIR_LEFT: begin
                drive.left_rev  = 1'b1;
                drive.right_fwd = 1'b1;
            end
            DIR_RIGHT: begin
                drive.left_fwd  = 1'b1;
                drive.right_rev = 1'b1;
            end
            default: begin
                drive.left_duty  = DUTY_OFF;
                drive.right_duty = DUTY_OFF;
            end
        endcase
    end

endmodule

// File: hdl/lfdc_turn.sv
// Turn state, turn and blink timers, and indicator lamp control.
module lfdc_turn #(
    parameter int TIMER_BITS = lfdc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [lfdc_pkg::DIR_BITS-1:0] direction_cmd,
    input  logic                          sensor_left,
    input  logic                          sensor_middle,
    input  logic                          sensor_right,
    input  logic [lfdc_pkg::CFG_BITS-1:0] blink_period,
    input  logic [lfdc_pkg::CFG_BITS-1:0] turn_settle,
    output lfdc_pkg::turn_status_t        status
);
    import lfdc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    logic                  turning_reg, turning_next;
    logic [TIMER_BITS-1:0] turn_elapsed_reg, turn_elapsed_next;
    logic [TIMER_BITS-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic                  blink_phase_reg, blink_phase_next;
    logic                  left_lamp_reg, left_lamp_next;
    logic                  right_lamp_reg, right_lamp_next;
    logic [TIMER_BITS-1:0] turn_inc, blink_inc;
    logic                  done, toggle, known;
    dir_t                  dir;

    assign dir   = sanitize_dir(direction_cmd);
    assign known = (classify(sensor_left, sensor_middle, sensor_right) != PAT_UNKNOWN);

    // Both timers run for the whole turn and saturate at all ones.
    assign turn_inc  = !turning_reg ? turn_elapsed_reg :
                       (turn_elapsed_reg == TIMER_MAX) ? TIMER_MAX :
                       turn_elapsed_reg + TIMER_BITS'(1);
    assign blink_inc = !turning_reg ? blink_elapsed_reg :
                       (blink_elapsed_reg == TIMER_MAX) ? TIMER_MAX :
                       blink_elapsed_reg + TIMER_BITS'(1);
    assign toggle    = CMP_W'(blink_inc) > CMP_W'(blink_period);

    always_comb begin
        turning_next       = turning_reg;
        turn_elapsed_next  = turn_inc;
        blink_elapsed_next = blink_inc;
        blink_phase_next   = blink_phase_reg;
        left_lamp_next     = left_lamp_reg;
        right_lamp_next    = right_lamp_reg;
        done               = 1'b0;
        if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
            if (!turning_reg) begin
                turning_next       = 1'b1;
                turn_elapsed_next  = '0;
                blink_elapsed_next = '0;
            end else begin
                if (toggle) begin
                    blink_phase_next   = !blink_phase_reg;
                    blink_elapsed_next = '0;
                end
                if (dir == DIR_LEFT) begin
                    right_lamp_next = 1'b0;
                    if (toggle) begin
                        left_lamp_next = !blink_phase_reg;
                    end
                end else begin
                    left_lamp_next = 1'b0;
                    if (toggle) begin
                        right_lamp_next = !blink_phase_reg;
                    end
                end
                if ((CMP_W'(turn_inc) > CMP_W'(turn_settle)) && known) begin
                    done             = 1'b1;
                    turning_next     = 1'b0;
                    blink_phase_next = 1'b0;
                    left_lamp_next   = 1'b0;
                    right_lamp_next  = 1'b0;
                end
            end
        end
    end

    assign status.left_lamp  = left_lamp_next;
    assign status.right_lamp = right_lamp_next;
    assign status.turn_done  = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turning_reg       <= 1'b0;
            turn_elapsed_reg  <= '0;
            blink_elapsed_reg <= '0;
            blink_phase_reg   <= 1'b0;
            left_lamp_reg     <= 1'b0;
            right_lamp_reg    <= 1'b0;
        end else if (step) begin
            turning_reg       <= turning_next;
            turn_elapsed_reg  <= turn_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            blink_phase_reg   <= blink_phase_next;
            left_lamp_reg     <= left_lamp_next;
            right_lamp_reg    <= right_lamp_next;
        end
    end

endmodule

// File: hdl/line_follow_drive_controller.sv
// Top level of the line-follow drive controller: handshakes, registers and pipeline.
//
// Usage: each transaction on the s_ channel is one control tick carrying the
// commanded direction, the speed and the three line-sensor bits. Every tick
// produces exactly one transaction on the m_ channel with the bridge pin
// levels, the two pwm duties, the brake light, the indicator lamps and the
// turn_done pulse. The cfg_ channel writes blink_period (index 0) and
// turn_settle (index 1); it is always ready and should only be used while no
// tick is in flight. Writes to other indexes are ignored.
// From s_ acceptance a tick passes through the input register, then through
// the drive and turn logic into the result register that drives m_valid.
// Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// keeps accepting until it is also full; s_ready then drops until m_ready
// returns. Synchronous reset (aresetn low) empties both stages, clears the
// turn state, timers and lamps, and restores blink_period to 300 and
// turn_settle to 1000 ticks.
module line_follow_drive_controller #(
    parameter int TIMER_BITS = lfdc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Tick input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lfdc_pkg::DIR_BITS-1:0]  s_direction_cmd,
    input  logic [lfdc_pkg::DUTY_BITS-1:0] s_speed,
    input  logic                           s_sensor_left,
    input  logic                           s_sensor_middle,
    input  logic                           s_sensor_right,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_left_fwd,
    output logic                           m_left_rev,
    output logic                           m_right_fwd,
    output logic                           m_right_rev,
    output logic [lfdc_pkg::DUTY_BITS-1:0] m_left_duty,
    output logic [lfdc_pkg::DUTY_BITS-1:0] m_right_duty,
    output logic                           m_brake_light,
    output logic                           m_left_indicator,
    output logic                           m_right_indicator,
    output logic                           m_turn_done,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfdc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [lfdc_pkg::CFG_BITS-1:0]  cfg_data
);
    import lfdc_pkg::*;

    logic [CFG_BITS-1:0]  blink_period_reg;
    logic [CFG_BITS-1:0]  turn_settle_reg;

    // Input stage.
    logic                 in_valid_reg;
    logic [DIR_BITS-1:0]  dir_reg;
    logic [DUTY_BITS-1:0] speed_reg;
    logic                 sl_reg, sm_reg, sr_reg;

    // Result stage.
    logic                 out_valid_reg;
    drive_t               drive_reg;
    turn_status_t         status_reg;

    drive_t               drive;
    turn_status_t         status;
    logic                 advance;
    logic                 step;

    // The result register can take a new value when empty or being drained.
    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= BLINK_PERIOD_RESET;
            turn_settle_reg  <= TURN_SETTLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data;
                CFG_TURN_SETTLE:  turn_settle_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            dir_reg   <= s_direction_cmd;
            speed_reg <= s_speed;
            sl_reg    <= s_sensor_left;
            sm_reg    <= s_sensor_middle;
            sr_reg    <= s_sensor_right;
        end
    end

    lfdc_drive u_drive (
        .direction_cmd (dir_reg),
        .speed         (speed_reg),
        .sensor_left   (sl_reg),
        .sensor_middle (sm_reg),
        .sensor_right  (sr_reg),
        .drive         (drive)
    );

    lfdc_turn #(
        .TIMER_BITS (TIMER_BITS)
    ) u_turn (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .direction_cmd (dir_reg),
        .sensor_left   (sl_reg),
        .sensor_middle (sm_reg),
        .sensor_right  (sr_reg),
        .blink_period  (blink_period_reg),
        .turn_settle   (turn_settle_reg),
        .status        (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            drive_reg  <= drive;
            status_reg <= status;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_left_fwd        = drive_reg.left_fwd;
    assign m_left_rev        = drive_reg.left_rev;
    assign m_right_fwd       = drive_reg.right_fwd;
    assign m_right_rev       = drive_reg.right_rev;
    assign m_left_duty       = drive_reg.left_duty;
    assign m_right_duty      = drive_reg.right_duty;
    assign m_brake_light     = (drive_reg.right_duty == DUTY_OFF);
    assign m_left_indicator  = status_reg.left_lamp;
    assign m_right_indicator = status_reg.right_lamp;
    assign m_turn_done       = status_reg.turn_done;

endmodule
